@@ rtl/lcbb_pkg.sv @@
// Package: constants, codes and types of the LRU cache with byte budget.
`timescale 1ns / 1ps
package lcbb_pkg;
	localparam int unsigned ENTRIES = 16;
	localparam int unsigned IDX_W = $clog2(ENTRIES);

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [2:0] RK_EVICTED  = 3'd0;
	localparam logic [2:0] RK_HIT      = 3'd1;
	localparam logic [2:0] RK_INSERTED = 3'd2;
	localparam logic [2:0] RK_NOTFOUND = 3'd3;
	localparam logic [2:0] RK_CLEARED  = 3'd4;

	localparam logic [1:0] ADDR_BUDGET = 2'd0;

	localparam logic [23:0] BUDGET_RESET = 24'd131072;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DEC   = 6'b000100,
		ST_EVICT = 6'b001000,
		ST_FILL  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;
endpackage

@@ rtl/lru_cache_with_byte_budget.sv @@
// Top level: LRU cache bookkeeping with a byte budget, memory-based scan.
`timescale 1ns / 1ps
// Flow: a request scans the slot memory, and a hit or not-found result follows that scan. A fill
// needs a second scan for the oldest entry, and each eviction ahead of it adds another scan.
// A new item is taken only in idle once the last result has been taken; a clear needs no scan.
// A waiting eviction result holds the next eviction or the fill. One memory read per cycle.
// Reset: valid bits, byte total, use counter and budget return to their reset values at once.
module lru_cache_with_byte_budget import lcbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata from bit 0: opcode[1:0], object_key[33:2], item_size[57:34], zero pad
	input  logic [63:0] s_tdata,
	// s_tuser: source_present
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata from bit 0: result_kind[2:0], slot_index[6:3], entry_key[38:7],
	// entry_size[62:39], bytes_in_use[90:63], zero pad
	output logic [95:0] m_tdata,
	// m_tlast: last_result
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

	// Slot memory: key, size, age. Read registered; valid bits in flops.
	logic [87:0]        mem [ENTRIES];
	logic [87:0]        rd_q;
	logic [ENTRIES-1:0] valid_q;
	logic [23:0]        budget_q;
	logic [27:0]        used_q;
	logic [31:0]        ctr_q;
	state_t             state_q;

	logic [1:0]  op_q;
	logic [31:0] key_q;
	logic [23:0] size_q;
	logic        pres_q;
	logic        evict_mode_q; // scan looks for oldest instead of a key match
	logic [CNT_W-1:0] ptr_q;   // read address of the scan
	logic [IDX_W-1:0] cmp_q;   // index of the entry in rd_q
	logic        rv_q;         // rd_q holds a scanned entry
	logic        hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic        old_q;
	logic [IDX_W-1:0] old_idx_q;
	logic [31:0] old_age_q;
	logic [55:0] old_ks_q;
	logic        wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [87:0] wr_data;

	logic [2:0]  o_kind_q;
	logic [IDX_W-1:0] o_slot_q;
	logic [31:0] o_key_q;
	logic [23:0] o_size_q;
	logic        o_last_q;
	logic        o_valid_q;

	logic        s_fire;
	logic        cfg_wr;
	logic        need;
	logic        free_any;
	logic [IDX_W-1:0] free_idx;
	logic        rd_valid;

	assign s_fire  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && !o_valid_q;
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (paddr == ADDR_BUDGET) ? {8'd0, budget_q} : 32'd0;
	assign m_tvalid = o_valid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {5'd0, used_q, o_size_q, o_key_q, 4'(o_slot_q), o_kind_q};
	assign rd_valid = valid_q[cmp_q];

	// Budget test uses 29 bits: total plus size may exceed 2^28.
	always_comb begin
		need = 1'b0;
		if ({1'b0, used_q} + {5'd0, size_q} > {5'd0, budget_q}) need = 1'b1;
	end

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[ptr_q[IDX_W-1:0]];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = {ctr_q + 32'd1, rd_q[55:0]};
		if (state_q == ST_DEC && hit_q && op_q == OP_LOAD && !evict_mode_q) begin
			wr_en = 1'b1;
			wr_data = {ctr_q + 32'd1, old_ks_q};
		end else if (state_q == ST_FILL) begin
			wr_en = 1'b1;
			wr_addr = free_idx;
			wr_data = {ctr_q + 32'd1, size_q, key_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			budget_q <= BUDGET_RESET;
			used_q <= '0;
			ctr_q <= '0;
			o_valid_q <= 1'b0;
			ptr_q <= '0;
			rv_q <= 1'b0;
			evict_mode_q <= 1'b0;
		end else begin
			if (cfg_wr && paddr == ADDR_BUDGET) budget_q <= pwdata[23:0];
			if (o_valid_q && m_tready) o_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						op_q <= s_tdata[1:0];
						key_q <= s_tdata[33:2];
						size_q <= s_tdata[57:34];
						pres_q <= s_tuser;
						if (s_tdata[1:0] == OP_CLEAR) begin
							valid_q <= '0;
							used_q <= '0;
							o_kind_q <= RK_CLEARED;
							o_slot_q <= '0;
							o_key_q <= '0;
							o_size_q <= '0;
							o_last_q <= 1'b1;
							o_valid_q <= 1'b1;
						end else if (s_tdata[1:0] != OP_NOP) begin
							state_q <= ST_SCAN;
							evict_mode_q <= 1'b0;
							ptr_q <= '0;
							rv_q <= 1'b0;
							hit_q <= 1'b0;
							old_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					// Advance the read pointer; compare the entry read last cycle.
					if (ptr_q != CNT_W'(ENTRIES)) ptr_q <= ptr_q + 1'b1;
					cmp_q <= ptr_q[IDX_W-1:0];
					rv_q <= (ptr_q != CNT_W'(ENTRIES));
					if (rv_q && rd_valid) begin
						if (!evict_mode_q && !hit_q && rd_q[31:0] == key_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= cmp_q;
							old_ks_q <= rd_q[55:0];
						end
						if (!old_q || rd_q[87:56] < old_age_q) begin
							old_q <= 1'b1;
							old_idx_q <= cmp_q;
							old_age_q <= rd_q[87:56];
							if (evict_mode_q) old_ks_q <= rd_q[55:0];
						end
					end
					if (!rv_q && ptr_q == CNT_W'(ENTRIES)) state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (!evict_mode_q && hit_q) begin
						if (op_q == OP_LOAD) ctr_q <= ctr_q + 32'd1;
						o_kind_q <= RK_HIT;
						o_slot_q <= hit_idx_q;
						o_key_q <= old_ks_q[31:0];
						o_size_q <= old_ks_q[55:32];
						o_last_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (!evict_mode_q && op_q == OP_LOAD && !pres_q) begin
						o_kind_q <= RK_NOTFOUND;
						o_slot_q <= '0;
						o_key_q <= key_q;
						o_size_q <= '0;
						o_last_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (!evict_mode_q) begin
						// Miss: rescan for the oldest entry.
						evict_mode_q <= 1'b1;
						ptr_q <= '0;
						rv_q <= 1'b0;
						old_q <= 1'b0;
						state_q <= ST_SCAN;
					end else if (o_valid_q) begin
						// Hold until the previous eviction result is taken.
						state_q <= ST_DEC;
					end else if (old_q && (need || !free_any)) begin
						state_q <= ST_EVICT;
					end else begin
						state_q <= ST_FILL;
					end
				end
				ST_EVICT: begin
					// Drop the victim and report it.
					valid_q[old_idx_q] <= 1'b0;
					used_q <= used_q - {4'd0, old_ks_q[55:32]};
					o_kind_q <= RK_EVICTED;
					o_slot_q <= old_idx_q;
					o_key_q <= old_ks_q[31:0];
					o_size_q <= old_ks_q[55:32];
					o_last_q <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_FILL: begin
					ctr_q <= ctr_q + 32'd1;
					valid_q[free_idx] <= 1'b1;
					used_q <= used_q + {4'd0, size_q};
					o_kind_q <= RK_INSERTED;
					o_slot_q <= free_idx;
					o_key_q <= key_q;
					o_size_q <= size_q;
					o_last_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!o_valid_q) begin
						o_valid_q <= 1'b1;
						if (o_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= '0;
							rv_q <= 1'b0;
							old_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// An eviction result never carries the last flag.
	a_evict_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == RK_EVICTED |-> !m_tlast)
		else $error("eviction marked last");
	// No new transfer while a result waits.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("accept while result pending");
	// A cleared result leaves no valid slot.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tdata[1:0] == OP_CLEAR |=> valid_q == '0 && used_q == '0)
		else $error("clear left state");
endmodule

@@ dv/lcbb_checker.sv @@
// Checker: predicts LRU cache results from observed transfers and compares them.
`timescale 1ns / 1ps
module lcbb_checker import lcbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [31:0] key;
		logic [23:0] size;
		logic [27:0] bytes;
		logic        last;
	} cache_result_t;

	cache_result_t expected_results[$];

	logic [23:0] budget;
	logic        valid_m [ENTRIES];
	logic [31:0] key_m   [ENTRIES];
	logic [23:0] size_m  [ENTRIES];
	logic [31:0] age_m   [ENTRIES];
	logic [27:0] used;
	logic [31:0] counter;

	function automatic int oldest_slot();
		int best;
		best = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (valid_m[i] && (best < 0 || age_m[i] < age_m[best]))
				best = i;
		return best;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < ENTRIES; i++)
			if (!valid_m[i])
				return i;
		return -1;
	endfunction

	function automatic void push_result(logic [2:0] kind, int slot, logic [31:0] key,
			logic [23:0] size, logic last);
		cache_result_t r;
		r.kind = kind;
		r.slot = slot[3:0];
		r.key = key;
		r.size = size;
		r.bytes = used;
		r.last = last;
		expected_results.push_back(r);
	endfunction

	function automatic void evict_slot(int v);
		used = used - {4'd0, size_m[v]};
		valid_m[v] = 1'b0;
		push_result(RK_EVICTED, v, key_m[v], size_m[v], 1'b0);
		size_m[v] = '0;
		age_m[v] = '0;
	endfunction

	function automatic void predict_request(logic [1:0] op, logic [31:0] key,
			logic [23:0] size, logic present);
		int h, v, f;
		h = -1;
		if (op == OP_CLEAR) begin
			for (int i = 0; i < ENTRIES; i++)
				valid_m[i] = 1'b0;
			used = '0;
			push_result(RK_CLEARED, 0, '0, '0, 1'b1);
			return;
		end
		if (op != OP_LOAD && op != OP_ADD)
			return;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (valid_m[i] && key_m[i] == key)
				h = i;
		if (h >= 0) begin
			if (op == OP_LOAD) begin
				counter++;
				age_m[h] = counter;
			end
			push_result(RK_HIT, h, key_m[h], size_m[h], 1'b1);
			return;
		end
		if (op == OP_LOAD && !present) begin
			push_result(RK_NOTFOUND, 0, key, '0, 1'b1);
			return;
		end
		while ({4'd0, used} + {8'd0, size} > {8'd0, budget}) begin
			v = oldest_slot();
			if (v < 0)
				break;
			evict_slot(v);
		end
		f = free_slot();
		if (f < 0) begin
			evict_slot(oldest_slot());
			f = free_slot();
		end
		counter++;
		valid_m[f] = 1'b1;
		key_m[f] = key;
		size_m[f] = size;
		age_m[f] = counter;
		used = used + {4'd0, size};
		push_result(RK_INSERTED, f, key, size, 1'b1);
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		cache_result_t got, want;
		if (!arst_n) begin
			budget = BUDGET_RESET;
			used = '0;
			counter = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				valid_m[i] = 1'b0;
				key_m[i] = '0;
				size_m[i] = '0;
				age_m[i] = '0;
			end
			expected_results.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_BUDGET)
				budget = pwdata[23:0];
			// compare output before predicting, so a same-edge input cannot race ahead
			if (m_tvalid && m_tready) begin
				got = {m_tdata[2:0], m_tdata[6:3], m_tdata[38:7], m_tdata[62:39],
					m_tdata[90:63], m_tlast};
				results_seen++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: kind %0d/%0d slot %0d/%0d key %h/%h",
								" size %0d/%0d bytes %0d/%0d last %0d/%0d (exp/act)"},
								want.kind, got.kind, want.slot, got.slot,
								want.key, got.key, want.size, got.size,
								want.bytes, got.bytes, want.last, got.last);
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_request(s_tdata[1:0], s_tdata[33:2], s_tdata[57:34], s_tuser);
		end
	end
endmodule

@@ dv/tb_top.sv @@
// Testbench top: stimulus, register writes and verdict for the LRU cache with byte budget.
`timescale 1ns / 1ps
module tb_top;
	import lcbb_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count, pending, results_seen;
	int idle_cycles = 0;
	int items_sent = 0;
	logic stall_on = 1'b0;

	// small working set of keys so hits and LRU reuse happen often
	logic [31:0] key_pool [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lru_cache_with_byte_budget dut (.*);

	lcbb_checker chk (.*);

	// receiver drops ready at random, about a quarter of the time, once stalls are on
	always @(posedge clk) begin
		if (stall_on)
			m_tready <= ($urandom_range(0, 3) != 0);
		else
			m_tready <= 1'b1;
	end

	// watchdog: count cycles in which nothing moves on either channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// send one request and hold it until the transfer
	task automatic send_request(logic [1:0] op, logic [31:0] key, logic [23:0] size,
			logic present);
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, size, key, op};
		s_tuser <= present;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drop_valid();
		s_tvalid <= 1'b0;
	endtask

	// wait until every expected result is back, then let the block settle
	task automatic drain_results();
		drop_valid();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_budget(logic [23:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_BUDGET;
		pwdata <= {8'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// random request, mostly loads and adds from the key pool
	task automatic random_request(logic [23:0] size_max);
		logic [1:0] op;
		logic [31:0] key;
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) op = OP_LOAD;
		else if (r < 90) op = OP_ADD;
		else if (r < 95) op = OP_CLEAR;
		else op = OP_NOP;
		key = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
		send_request(op, key, 24'($urandom_range(0, size_max)),
			$urandom_range(0, 5) != 0);
	endtask

	initial begin
		logic [23:0] size_max;
		for (int i = 0; i < 8; i++)
			key_pool[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every operation and the special cases
		send_request(OP_LOAD, 32'h0000_0000, 24'd0, 1'b0);          // not found
		send_request(OP_LOAD, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1);   // oversize fill
		send_request(OP_LOAD, 32'hFFFF_FFFF, 24'd5, 1'b1);         // hit refreshes age
		send_request(OP_ADD, 32'hFFFF_FFFF, 24'd7, 1'b0);          // hit on add
		send_request(OP_ADD, 32'h0000_0001, 24'd100, 1'b0);        // evicts the oversize one
		send_request(OP_NOP, 32'hA5A5_A5A5, 24'h5A_5A5A, 1'b1);    // ignored opcode
		send_request(OP_CLEAR, 32'h1234_5678, 24'd1, 1'b1);
		drain_results();
		write_budget(24'hFF_FFFF);
		// fill past sixteen slots so the full-cache eviction happens
		for (int i = 0; i < 18; i++)
			send_request(OP_ADD, 32'h100 + i, 24'(24'h0F_0000 + i), 1'b1);
		drain_results();

		// random phases over several budgets, the extremes among them
		stall_on = 1'b1;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin write_budget(24'd0); size_max = 24'd300; end
				1: begin write_budget(24'd1000); size_max = 24'd300; end
				2: begin write_budget(BUDGET_RESET); size_max = 24'd40000; end
				3: begin write_budget(24'hFF_FFFF); size_max = 24'hFF_FFFF; end
				default: begin
					write_budget(24'($urandom_range(1, 4095)));
					size_max = 24'd1024;
				end
			endcase
			for (int n = 0; n < 60; n++) begin
				random_request(size_max);
				// random gap between bursts of back-to-back requests
				if ($urandom_range(0, 3) == 0) begin
					drop_valid();
					repeat ($urandom_range(1, 30)) @(posedge clk);
				end
			end
			drain_results();
		end

		drop_valid();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d requests and %0d results over six budget settings",
			items_sent, results_seen);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/lcbb_pkg.sv
rtl/lru_cache_with_byte_budget.sv
dv/lcbb_checker.sv
dv/tb_top.sv
